// ===== sv/lsela_pkg.sv =====
// ----------------------------------------------------------------------------
// lsela_pkg
// Types, constants and the softplus table for the log-sum-exp accumulator.
// ----------------------------------------------------------------------------
package lsela_pkg;

	localparam int FRAC_BITS        = 16;
	localparam int SOFTPLUS_ENTRIES = 256;
	localparam int IDX_W            = $clog2(SOFTPLUS_ENTRIES);

	localparam int CNT_W   = 12;
	localparam int LOG_W   = 21;
	localparam int FRAC_W  = 17;
	localparam int ACC_W   = 48;
	localparam int E_W     = 32;             // e1, e2, e3
	localparam int PROD_W  = E_W + LOG_W;    // one product
	localparam int FULL_W  = PROD_W + 1;     // sum of two products
	localparam int LSE_W   = FULL_W - FRAC_BITS + 2;
	localparam int DIFF_W  = LSE_W + 1;

	localparam logic signed [LOG_W-1:0] LOG_RESET = -LOG_W'(45426);

	// Configuration register indexes
	localparam logic [1:0] REG_TRIAL  = 2'd0;
	localparam logic [1:0] REG_PRIOR  = 2'd1;
	localparam logic [1:0] REG_LALPHA = 2'd2;
	localparam logic [1:0] REG_LOMA   = 2'd3;

	typedef struct packed {
		logic [FRAC_W-1:0] mean_value;
		logic [FRAC_W-1:0] weight_value;
		logic              last_item;
	} in_item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] neg_log_lik;
		logic                    final_result;
	} out_item_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_E1,
		OP_E2,
		OP_E3,
		OP_A1L,
		OP_A1H,
		OP_A2L,
		OP_A2H,
		OP_B1,
		OP_B2,
		OP_F1,
		OP_F2,
		OP_ACC
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef logic [FRAC_BITS-1:0] sp_rom_t [SOFTPLUS_ENTRIES];

	localparam longint unsigned Q31_ONE = 64'd1 << 31;

	// Shift-and-subtract quotient, used only while building the table
	function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = (r << 1) | ((num >> b) & 64'd1);
			if (r >= den) begin
				r = r - den;
				q = q | (64'd1 << b);
			end
		end
		return q;
	endfunction

	// e^-(k/E) by series, then raised to the sixteenth power, Q31
	function automatic longint unsigned exp_neg(longint unsigned k);
		longint unsigned g;
		longint unsigned term;
		longint unsigned a;
		longint          sum;
		g    = (k << 31) >> IDX_W;
		term = Q31_ONE;
		sum  = longint'(Q31_ONE);
		for (int i = 1; i <= 24; i++) begin
			term = udiv((term * g) >> 31, longint'(i));
			if ((i & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		a = longint'(sum);
		for (int i = 0; i < 4; i++) begin
			a = (a * a + (Q31_ONE >> 1)) >> 31;
		end
		return a;
	endfunction

	// ln(1+y) for y in [0,1], Q31, via 2*atanh(y/(2+y))
	function automatic longint unsigned log_one_plus(longint unsigned y);
		longint unsigned z;
		longint unsigned z2;
		longint unsigned p;
		longint unsigned acc;
		z   = udiv(y << 31, 2 * Q31_ONE + y);
		z2  = (z * z) >> 31;
		p   = z;
		acc = 0;
		for (int j = 0; j < 24; j++) begin
			acc = acc + udiv(p, longint'(2 * j + 1));
			p   = (p * z2) >> 31;
		end
		return 2 * acc;
	endfunction

	function automatic sp_rom_t build_rom();
		sp_rom_t         r;
		longint unsigned v;
		for (int k = 0; k < SOFTPLUS_ENTRIES; k++) begin
			v    = log_one_plus(exp_neg(longint'(k)));
			r[k] = FRAC_BITS'((v + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
		end
		return r;
	endfunction

	localparam sp_rom_t SP_ROM = build_rom();

endpackage

// ===== sv/lsela_dp.sv =====
// ----------------------------------------------------------------------------
// lsela_dp
// Datapath: configuration registers, one shared multiplier, log-sum-exp unit
// and the saturating running sum with its output register.
// ----------------------------------------------------------------------------
module lsela_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [20:0]         cfg_data,
	input  lsela_pkg::in_item_t in_data,
	input  lsela_pkg::dp_cmd_t  cmd,
	output lsela_pkg::out_item_t out_data
);
	import lsela_pkg::*;

	localparam logic signed [E_W-1:0]    ONE_E   = E_W'(1) <<< FRAC_BITS;
	localparam logic signed [FULL_W-1:0] HALF_F  = FULL_W'(1) <<< (FRAC_BITS - 1);
	localparam logic [DIFF_W-1:0]        SP_SPAN = DIFF_W'(16) << FRAC_BITS;
	localparam int                       SPI_W   = FRAC_BITS + 4 + 14;
	localparam logic signed [ACC_W+1:0]  ACC_MAX = (ACC_W+2)'((64'd1 << (ACC_W - 1)) - 1);
	localparam logic signed [ACC_W+1:0]  ACC_MIN = -((ACC_W+2)'(1) <<< (ACC_W - 1));

	logic [CNT_W-1:0]        n_q, n0_q;
	logic signed [LOG_W-1:0] la_q, lb_q;
	logic [FRAC_W-1:0]       g_q, w_q;
	logic                    last_q;
	logic signed [E_W-1:0]   e1_q, e2_q, e3_q;
	logic signed [FULL_W-1:0] a1_q, a2_q, b1_q, b2_q;
	logic signed [LSE_W-1:0] f1_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [ACC_W-1:0] sum_q;

	logic signed [E_W-1:0]    mul_a;
	logic signed [LOG_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [FULL_W-1:0] prod_x;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q  <= CNT_W'(1);
			n0_q <= '0;
			la_q <= LOG_RESET;
			lb_q <= LOG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TRIAL:  n_q  <= cfg_data[CNT_W-1:0];
				REG_PRIOR:  n0_q <= cfg_data[CNT_W-1:0];
				REG_LALPHA: la_q <= $signed(cfg_data);
				REG_LOMA:   lb_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_E1: begin
				mul_a = $signed(E_W'(g_q));
				mul_b = $signed(LOG_W'(n_q));
			end
			OP_E2: begin
				mul_a = ONE_E - $signed(E_W'({w_q, 1'b0}));
				mul_b = $signed(LOG_W'(n0_q));
			end
			OP_E3: begin
				mul_a = ONE_E - $signed(E_W'(g_q));
				mul_b = $signed(LOG_W'(n_q));
			end
			OP_A1L: begin mul_a = e1_q; mul_b = la_q; end
			OP_A1H: begin mul_a = e3_q; mul_b = lb_q; end
			OP_A2L: begin mul_a = e3_q; mul_b = la_q; end
			OP_A2H: begin mul_a = e1_q; mul_b = lb_q; end
			OP_B1:  begin mul_a = e2_q; mul_b = la_q; end
			OP_B2:  begin mul_a = e2_q; mul_b = lb_q; end
			default: ;
		endcase
	end

	assign prod   = PROD_W'(mul_a * mul_b);
	assign prod_x = FULL_W'(prod);

	// Log-sum-exp of the selected pair
	logic signed [FULL_W-1:0] lx_raw, ly_raw, lx_r, ly_r;
	logic signed [LSE_W-1:0]  lx, ly, lmax;
	logic [DIFF_W-1:0]        ld;
	logic [SPI_W-1:0]         sp_scaled;
	logic [IDX_W-1:0]         sp_idx;
	logic signed [LSE_W-1:0]  lse_out;

	always_comb begin
		lx_raw    = (cmd.op == OP_F1) ? a1_q : b1_q;
		ly_raw    = (cmd.op == OP_F1) ? a2_q : b2_q;
		lx_r      = (lx_raw + HALF_F) >>> FRAC_BITS;
		ly_r      = (ly_raw + HALF_F) >>> FRAC_BITS;
		lx        = lx_r[LSE_W-1:0];
		ly        = ly_r[LSE_W-1:0];
		lmax      = (lx > ly) ? lx : ly;
		ld        = (lx > ly) ? DIFF_W'(DIFF_W'(lx) - DIFF_W'(ly))
		                      : DIFF_W'(DIFF_W'(ly) - DIFF_W'(lx));
		sp_scaled = SPI_W'(ld[FRAC_BITS+3:0]) * SPI_W'(SOFTPLUS_ENTRIES);
		sp_idx    = IDX_W'(sp_scaled >> (FRAC_BITS + 4));
		if (ld >= SP_SPAN) begin
			lse_out = lmax;
		end else begin
			lse_out = lmax + $signed(LSE_W'(SP_ROM[sp_idx]));
		end
	end

	// Saturating accumulate and negate
	logic signed [ACC_W+1:0] s_wide, s_sat;
	logic signed [ACC_W-1:0] s_new, neg;

	always_comb begin
		s_wide = (ACC_W+2)'(sum_q) + (ACC_W+2)'(diff_q);
		if (s_wide > ACC_MAX) begin
			s_sat = ACC_MAX;
		end else if (s_wide < ACC_MIN) begin
			s_sat = ACC_MIN;
		end else begin
			s_sat = s_wide;
		end
		s_new = s_sat[ACC_W-1:0];
		neg   = (s_sat == ACC_MIN) ? ACC_MAX[ACC_W-1:0] : -s_new;
	end

	// Running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.op == OP_ACC) begin
			sum_q <= last_q ? '0 : s_new;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				g_q    <= in_data.mean_value;
				w_q    <= in_data.weight_value;
				last_q <= in_data.last_item;
			end
			OP_E1:  e1_q <= prod[E_W-1:0];
			OP_E2:  e2_q <= prod[E_W-1:0];
			OP_E3:  e3_q <= prod[E_W-1:0] + e2_q;
			OP_A1L: a1_q <= prod_x;
			OP_A1H: a1_q <= a1_q + prod_x;
			OP_A2L: a2_q <= prod_x;
			OP_A2H: a2_q <= a2_q + prod_x;
			OP_B1:  b1_q <= prod_x;
			OP_B2:  b2_q <= prod_x;
			OP_F1:  f1_q <= lse_out;
			OP_F2:  diff_q <= DIFF_W'(f1_q) - DIFF_W'(lse_out);
			OP_ACC: begin
				out_data.neg_log_lik  <= neg;
				out_data.final_result <= last_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/lsela_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsela_ctrl
// Controller: steps the datapath through one transaction and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module lsela_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output lsela_pkg::dp_cmd_t cmd
);
	import lsela_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_E1, S_E2, S_E3, S_A1L, S_A1H, S_A2L, S_A2H,
		S_B1, S_B2, S_F1, S_F2, S_ACC
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// Issue the operation for the current step
	always_comb begin
		case (state_q)
			S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_E1:    cmd.op = OP_E1;
			S_E2:    cmd.op = OP_E2;
			S_E3:    cmd.op = OP_E3;
			S_A1L:   cmd.op = OP_A1L;
			S_A1H:   cmd.op = OP_A1H;
			S_A2L:   cmd.op = OP_A2L;
			S_A2H:   cmd.op = OP_A2H;
			S_B1:    cmd.op = OP_B1;
			S_B2:    cmd.op = OP_B2;
			S_F1:    cmd.op = OP_F1;
			S_F2:    cmd.op = OP_F2;
			S_ACC:   cmd.op = out_free ? OP_ACC : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	// Advance state; hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (state_q == S_ACC && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_E1;
				end
				S_E1:  state_q <= S_E2;
				S_E2:  state_q <= S_E3;
				S_E3:  state_q <= S_A1L;
				S_A1L: state_q <= S_A1H;
				S_A1H: state_q <= S_A2L;
				S_A2L: state_q <= S_A2H;
				S_A2H: state_q <= S_B1;
				S_B1:  state_q <= S_B2;
				S_B2:  state_q <= S_F1;
				S_F1:  state_q <= S_F2;
				S_F2:  state_q <= S_ACC;
				S_ACC: if (out_free) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/log_sum_exp_likelihood_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// log_sum_exp_likelihood_accumulator_core
// Streams Q1.16 mean/weight pairs and emits the negated running log-sum-exp
// likelihood after each transaction.
// ----------------------------------------------------------------------------
// One transaction at a time: after the load step the single shared multiplier
// takes nine steps, followed by two log-sum-exp steps and the accumulate, and
// only then is a new input accepted. A result left waiting holds the accumulate
// step.
// Reset: asynchronous, active low; clears the running sum and control state
// and loads the register defaults. The softplus table is constant.
module log_sum_exp_likelihood_accumulator_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [20:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lsela_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lsela_pkg::out_item_t out_data
);
	import lsela_pkg::*;

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	lsela_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	lsela_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	// One transaction in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a transaction is in flight");

	// A fresh result only follows work in progress
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without a transaction in flight");
`endif

endmodule
